### design/kbuf_pkg.sv
// ----------------------------------------------------------------------------
// kbuf_pkg
// Shared types, constants and the modifier flag table of the keyboard
// event buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package kbuf_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int KEY_COUNT_DEF  = 256;
  localparam int MODIFIER_BASE  = 215;
  localparam int MOD_COUNT      = 12;

  localparam int ACT_W  = 2;
  localparam int KEY_W  = 8;
  localparam int CHAR_W = 21;
  localparam int MOD_W  = 10;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [MOD_W-1:0] PLAIN_MASK = 10'h07F;
  localparam logic [MOD_W-1:0] LOCK_MASK  = 10'h380;
  localparam int               ALT_BIT    = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_DOWN   = 2'd0,
    ACT_REPEAT = 2'd1,
    ACT_UP     = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REG_REPEAT_EN      = 2'd0,
    REG_LOCK_TOGGLE_EN = 2'd1,
    REG_LED_FOLLOW_EN  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic repeat_en;
    logic lock_toggle_en;
    logic led_follow_en;
  } kbuf_cfg_t;

  // Flags in key order: lshift, rshift, lctrl, rctrl, alt, altgr, lwin,
  // rwin, menu, scroll, num, caps.
  localparam logic [MOD_W-1:0] MOD_FLAGS [MOD_COUNT] = '{
    10'h001, 10'h001, 10'h002, 10'h002, 10'h004, 10'h008,
    10'h010, 10'h020, 10'h040, 10'h080, 10'h100, 10'h200
  };

  function automatic logic [MOD_W-1:0] flag_of(input logic [KEY_W-1:0] code);
    logic [KEY_W:0]   diff;
    logic [MOD_W-1:0] flag;
    diff = {1'b0, code} - (KEY_W+1)'(MODIFIER_BASE);
    flag = '0;
    if (code >= KEY_W'(MODIFIER_BASE) && diff[KEY_W-1:0] < KEY_W'(MOD_COUNT)) begin
      flag = MOD_FLAGS[diff[3:0]];
    end
    return flag;
  endfunction

endpackage

`default_nettype wire

### design/kbuf_ram.sv
// ----------------------------------------------------------------------------
// kbuf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kbuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/kbuf_regs.sv
// ----------------------------------------------------------------------------
// kbuf_regs
// APB-style configuration registers of the keyboard event buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module kbuf_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [kbuf_pkg::APB_AW-1:0] paddr,
  input  wire logic [kbuf_pkg::APB_DW-1:0] pwdata,
  output logic      [kbuf_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output kbuf_pkg::kbuf_cfg_t             cfg
);

  import kbuf_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_en      <= 1'b1;
      cfg.lock_toggle_en <= 1'b1;
      cfg.led_follow_en  <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_REPEAT_EN:      cfg.repeat_en      <= pwdata[0];
        REG_LOCK_TOGGLE_EN: cfg.lock_toggle_en <= pwdata[0];
        REG_LED_FOLLOW_EN:  cfg.led_follow_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_REPEAT_EN:      prdata[0] = cfg.repeat_en;
      REG_LOCK_TOGGLE_EN: prdata[0] = cfg.lock_toggle_en;
      REG_LED_FOLLOW_EN:  prdata[0] = cfg.led_follow_en;
      default:            prdata    = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/keyboard_event_buffer_top.sv
// An accepted item is registered, then executed in ST_EXEC, where its result
// is registered once the output is free; no new item is accepted until then.
// The held-bit RAM and ring RAM are read in the accept cycle and written back
// when the item executes. Reset: synchronous; afterwards the held-bit RAM is
// cleared one entry per cycle, and no item is accepted until it is all clear.
// ----------------------------------------------------------------------------
// keyboard_event_buffer_top
// Key event tracker with held bits, modifier flags and a character ring.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_event_buffer_top #(
  parameter int RING_DEPTH = kbuf_pkg::RING_DEPTH_DEF,
  parameter int KEY_COUNT  = kbuf_pkg::KEY_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [kbuf_pkg::ACT_W-1:0]  action,
  input  wire logic [kbuf_pkg::KEY_W-1:0]  key_code,
  input  wire logic [kbuf_pkg::CHAR_W-1:0] char_code,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             read_valid,
  output logic      [kbuf_pkg::CHAR_W-1:0] read_char,
  output logic      [kbuf_pkg::KEY_W-1:0]  read_scan,
  output logic                             buffer_empty,
  output logic                             push_dropped,
  output logic      [kbuf_pkg::MOD_W-1:0]  modifier_bits,
  output logic                             led_update,
  output logic                             key_is_held,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kbuf_pkg::APB_AW-1:0] paddr,
  input  wire logic [kbuf_pkg::APB_DW-1:0] pwdata,
  output logic      [kbuf_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  import kbuf_pkg::*;

  localparam int PW     = $clog2(RING_DEPTH);
  localparam int KW     = $clog2(KEY_COUNT);
  localparam int ENTRY_W = CHAR_W + KEY_W;

  kbuf_cfg_t cfg;

  kbuf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state, state_next;
  logic [KW-1:0]     clr_cnt;
  logic [PW-1:0]     head, head_next;
  logic [PW-1:0]     tail, tail_next;
  logic [MOD_W-1:0]  modifiers, mod_next;

  act_t              item_action;
  logic [KEY_W-1:0]  item_key;
  logic [CHAR_W-1:0] item_char;

  logic              fire;
  logic              held_we, held_wdata, held_rdata;
  logic [KW-1:0]     held_waddr, held_raddr;
  logic              ring_we;
  logic [ENTRY_W-1:0] ring_wdata, ring_rdata;

  logic              press, release_key, in_range, is_mod_code, full, not_empty;
  logic [MOD_W-1:0]  flag;
  logic [CHAR_W-1:0] push_char;
  logic              held_now;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  kbuf_ram #(.WIDTH(1), .DEPTH(KEY_COUNT)) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  kbuf_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (tail),
    .wdata (ring_wdata),
    .raddr (head),
    .rdata (ring_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign fire     = (state == ST_EXEC) && (!out_valid || out_ready);

  // The held RAM is read with the arriving key in the accept cycle.
  assign held_raddr = (state == ST_IDLE) ? key_code[KW-1:0] : item_key[KW-1:0];

  always_comb begin
    press       = (item_action == ACT_DOWN) ||
                  (item_action == ACT_REPEAT && cfg.repeat_en);
    release_key = (item_action == ACT_UP);
    in_range    = {1'b0, item_key} < (KEY_W+1)'(KEY_COUNT);
    is_mod_code = item_key >= KEY_W'(MODIFIER_BASE);
    flag        = flag_of(item_key);
    full        = ring_next(tail) == head;
    not_empty   = head != tail;

    mod_next = modifiers;
    if (press) begin
      if ((flag & PLAIN_MASK) != '0) begin
        mod_next = modifiers | flag;
      end else if ((flag & LOCK_MASK) != '0 && cfg.lock_toggle_en) begin
        mod_next = modifiers ^ flag;
      end
    end else if (release_key && (flag & PLAIN_MASK) != '0) begin
      mod_next = modifiers & ~flag;
    end

    push_char  = mod_next[ALT_BIT] ? '0 : item_char;
    ring_wdata = {push_char, item_key};
    ring_we    = fire && press && !is_mod_code && !full;
    tail_next  = ring_we ? ring_next(tail) : tail;
    head_next  = (fire && item_action == ACT_READ && not_empty) ? ring_next(head) : head;

    if (!in_range) begin
      held_now = 1'b0;
    end else if (press) begin
      held_now = 1'b1;
    end else if (release_key) begin
      held_now = 1'b0;
    end else begin
      held_now = held_rdata;
    end

    if (state == ST_CLEAR) begin
      held_we    = 1'b1;
      held_waddr = clr_cnt;
      held_wdata = 1'b0;
    end else begin
      held_we    = fire && in_range && (press || release_key);
      held_waddr = item_key[KW-1:0];
      held_wdata = press;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == KW'(KEY_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  if (fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      head      <= '0;
      tail      <= '0;
      modifiers <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + KW'(1);
      end
      head <= head_next;
      tail <= tail_next;
      if (fire) begin
        modifiers <= mod_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_action <= act_t'(action);
      item_key    <= key_code;
      item_char   <= char_code;
    end
    if (fire) begin
      read_valid    <= (item_action == ACT_READ) && not_empty;
      read_char     <= ((item_action == ACT_READ) && not_empty) ?
                       ring_rdata[ENTRY_W-1:KEY_W] : '0;
      read_scan     <= ((item_action == ACT_READ) && not_empty) ?
                       ring_rdata[KEY_W-1:0] : '0;
      buffer_empty  <= head_next == tail_next;
      push_dropped  <= press && !is_mod_code && full;
      modifier_bits <= mod_next;
      led_update    <= cfg.led_follow_en && (((modifiers ^ mod_next) & LOCK_MASK) != '0);
      key_is_held   <= held_now;
    end
  end

endmodule

`default_nettype wire

### design/kbuf_checker.sv
// ----------------------------------------------------------------------------
// kbuf_checker
// Port-level checks of the keyboard event buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kbuf_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        read_valid,
  input wire logic [kbuf_pkg::CHAR_W-1:0] read_char,
  input wire logic [kbuf_pkg::KEY_W-1:0]  read_scan,
  input wire logic                        buffer_empty,
  input wire logic                        push_dropped
);

  // No result may appear in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // An item that removed nothing reports a zero character and scancode.
  a_no_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid) |-> (read_char == '0 && read_scan == '0))
    else $error("nonzero read data without a removed entry");

  // A dropped push means the buffer was full, so it cannot be empty.
  a_drop_not_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && push_dropped) |-> !buffer_empty)
    else $error("push dropped while buffer reported empty");

  // A read never pushes, so it never drops a character.
  a_read_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_valid) |-> !push_dropped)
    else $error("read item reported a dropped push");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_char) && $stable(read_scan)))
    else $error("stalled result changed");

endmodule

bind keyboard_event_buffer_top kbuf_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_valid   (read_valid),
  .read_char    (read_char),
  .read_scan    (read_scan),
  .buffer_empty (buffer_empty),
  .push_dropped (push_dropped)
);

`default_nettype wire
